// ----- hdl/gsss_pkg.sv -----
package gsss_pkg;

  localparam int MAX_MEMBERS_DEF = 64;
  localparam int ID_BITS_DEF = 16;
  localparam logic signed [31:0] UNDEF_COLOR_RST = -32'sd32766;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FILL,
    ST_CE_RD,
    ST_CE_CMP,
    ST_CE_WR2,
    ST_FWD_RD,
    ST_FWD_WR,
    ST_BWD_RD,
    ST_BWD_WR,
    ST_EM_RD,
    ST_EM_OUT
  } state_t;

  // per sorted position, left by the forward scan
  typedef struct packed {
    logic       nul;
    logic       lv;
    logic [5:0] gidx;
    logic [5:0] nrank;
  } scan_t;

endpackage

// ----- hdl/gsss_if.sv -----
interface gsss_in_if #(parameter int ID_BITS = gsss_pkg::ID_BITS_DEF);
  logic                valid;
  logic                ready;
  logic signed [31:0]  color;
  logic signed [31:0]  sort_key;
  logic [ID_BITS-1:0]  member_id;
  logic                last_member;
  modport source(output valid, color, sort_key, member_id, last_member, input ready);
  modport sink(input valid, color, sort_key, member_id, last_member, output ready);
endinterface

interface gsss_out_if #(parameter int ID_BITS = gsss_pkg::ID_BITS_DEF);
  logic               valid;
  logic               ready;
  logic               left_valid;
  logic [ID_BITS-1:0] left_id;
  logic               right_valid;
  logic [ID_BITS-1:0] right_id;
  logic [5:0]         new_rank;
  logic [6:0]         group_len;
  logic [5:0]         group_index;
  logic [6:0]         group_total;
  logic               null_group;
  logic               last_result;
  modport source(output valid, left_valid, left_id, right_valid, right_id, new_rank,
                 group_len, group_index, group_total, null_group, last_result,
                 input ready);
  modport sink(input valid, left_valid, left_id, right_valid, right_id, new_rank,
               group_len, group_index, group_total, null_group, last_result,
               output ready);
endinterface

interface gsss_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- hdl/group_split_sort_scan.sv -----
// throughput: one member beat per cycle while loading; a result beat is read from the
//   result memory before it is offered, and the next is read only after it is taken;
//   the bitonic network does each compare-exchange on the one sort memory as a read,
//   a compare with the write of the low entry, then the write of the high entry
// reset: synchronous, clears the member count and returns to loading; no clearing pass
module group_split_sort_scan #(
  parameter int MAX_MEMBERS = gsss_pkg::MAX_MEMBERS_DEF,
  parameter int ID_BITS = gsss_pkg::ID_BITS_DEF
) (
  input logic clk,
  input logic rst,
  gsss_in_if.sink   items,
  gsss_out_if.source results,
  gsss_cfg_if.sink  cfg
);
  import gsss_pkg::*;

  localparam int AW = (MAX_MEMBERS > 2) ? $clog2(MAX_MEMBERS) : 1;
  localparam int P = 1 << AW;
  localparam int NW = AW + 1;
  localparam int KW = $clog2(AW + 1);
  localparam logic [AW-1:0] HALF_M1 = AW'(P / 2 - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(P - 1);

  typedef struct packed {
    logic               pad;
    logic [31:0]        color;
    logic [31:0]        key;
    logic [AW-1:0]      rank;
    logic [ID_BITS-1:0] id;
  } ent_t;

  typedef struct packed {
    logic               lv;
    logic [ID_BITS-1:0] lid;
    logic               rv;
    logic [ID_BITS-1:0] rid;
    logic [5:0]         nrank;
    logic [6:0]         gsize;
    logic [5:0]         gidx;
    logic               nul;
  } res_t;

  function automatic logic sorts_ahead(ent_t a, ent_t b);
    logic [AW+64:0] key_a, key_b;
    key_a = {a.pad, ~a.color[31], a.color[30:0], ~a.key[31], a.key[30:0], a.rank};
    key_b = {b.pad, ~b.color[31], b.color[30:0], ~b.key[31], b.key[30:0], b.rank};
    return key_a < key_b;
  endfunction

  state_t state, state_next;
  logic [NW-1:0] count;
  logic [31:0] undef_color;
  logic [AW-1:0] f, t, p, e;
  logic [KW-1:0] kb, jb;
  ent_t ce_hi;
  logic [31:0] prev_color;
  logic [5:0] run_rank;
  logic [NW-1:0] runs;
  logic nxt_lv;
  logic [ID_BITS-1:0] nxt_id;
  logic [6:0] nxt_size;

  ent_t sort_mem [P];
  logic we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  ent_t wdata, rd_a, rd_b;

  res_t res_mem [P];
  logic we_r;
  logic [AW-1:0] waddr_r;
  res_t wdata_r, rq;

  logic acc_in, stored, acc_out;
  logic [NW-1:0] cnt_after, count_m1;
  logic [AW-1:0] mask, ce_i, ce_l, sh;
  logic asc, swap;
  ent_t lo_val, hi_val;
  logic newrun, p_last, rv;
  logic [5:0] nrank;
  logic [NW-1:0] runs_nx;
  logic [6:0] size;
  scan_t s_fw, s_bw;

  assign acc_in = items.valid && items.ready;
  assign acc_out = results.valid && results.ready;
  assign stored = count < NW'(MAX_MEMBERS);
  assign cnt_after = count + NW'(stored);
  assign count_m1 = count - NW'(1);
  assign p_last = {1'b0, p} == count_m1;

  assign mask = (AW'(1) << jb) - AW'(1);
  assign ce_i = ((t >> jb) << (jb + 1'b1)) | (t & mask);
  assign ce_l = ce_i | (AW'(1) << jb);
  assign sh = ce_i >> kb;
  assign asc = !sh[0];
  assign swap = asc ? sorts_ahead(rd_b, rd_a) : sorts_ahead(rd_a, rd_b);
  assign lo_val = swap ? rd_b : rd_a;
  assign hi_val = swap ? rd_a : rd_b;

  assign newrun = (p == '0) || (rd_a.color != prev_color);
  assign nrank = newrun ? 6'd0 : run_rank + 6'd1;
  assign runs_nx = runs + NW'(newrun);
  assign s_fw = '{nul: rd_a.color == undef_color, lv: !newrun,
                  gidx: 6'(runs_nx - NW'(1)), nrank: nrank};

  assign s_bw = scan_t'(rd_a.key[13:0]);
  assign rv = !p_last && nxt_lv;
  assign size = rv ? nxt_size : 7'(s_bw.nrank) + 7'd1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      undef_color <= UNDEF_COLOR_RST;
    end else if (cfg.valid && cfg.ready) begin
      undef_color <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      sort_mem[waddr] <= wdata;
    end
    rd_a <= sort_mem[raddr_a];
    rd_b <= sort_mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (we_r) begin
      res_mem[waddr_r] <= wdata_r;
    end
    rq <= res_mem[e];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    items.ready = 1'b0;
    results.valid = 1'b0;
    we = 1'b0;
    waddr = ce_i;
    wdata = lo_val;
    raddr_a = ce_i;
    raddr_b = ce_l;
    we_r = 1'b0;
    waddr_r = rd_a.rank;
    wdata_r = '{lv: s_bw.lv, lid: s_bw.lv ? rd_b.id : '0, rv: rv,
                rid: rv ? nxt_id : '0, nrank: s_bw.nrank, gsize: size,
                gidx: s_bw.gidx, nul: s_bw.nul};
    unique case (state)
      ST_LOAD: begin
        items.ready = 1'b1;
        waddr = count[AW-1:0];
        wdata = '{pad: 1'b0, color: items.color, key: items.sort_key,
                  rank: count[AW-1:0], id: items.member_id};
        if (acc_in) begin
          we = stored;
          if (items.last_member) begin
            state_next = (cnt_after == NW'(P)) ? ST_CE_RD : ST_FILL;
          end
        end
      end
      ST_FILL: begin
        we = 1'b1;
        waddr = f;
        wdata = '{pad: 1'b1, color: '0, key: '0, rank: f, id: '0};
        if (f == LAST_ADDR) begin
          state_next = ST_CE_RD;
        end
      end
      ST_CE_RD: begin
        state_next = ST_CE_CMP;
      end
      ST_CE_CMP: begin
        we = 1'b1;
        state_next = ST_CE_WR2;
      end
      ST_CE_WR2: begin
        we = 1'b1;
        waddr = ce_l;
        wdata = ce_hi;
        if (t == HALF_M1 && jb == '0 && kb == KW'(AW)) begin
          state_next = ST_FWD_RD;
        end else begin
          state_next = ST_CE_RD;
        end
      end
      ST_FWD_RD: begin
        raddr_a = p;
        state_next = ST_FWD_WR;
      end
      ST_FWD_WR: begin
        we = 1'b1;
        waddr = p;
        wdata = rd_a;
        wdata.key = 32'(s_fw);
        state_next = p_last ? ST_BWD_RD : ST_FWD_RD;
      end
      ST_BWD_RD: begin
        raddr_a = p;
        raddr_b = p - AW'(1);
        state_next = ST_BWD_WR;
      end
      ST_BWD_WR: begin
        we_r = 1'b1;
        state_next = (p == '0) ? ST_EM_RD : ST_BWD_RD;
      end
      ST_EM_RD: begin
        state_next = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        results.valid = 1'b1;
        if (acc_out) begin
          state_next = ({1'b0, e} == count_m1) ? ST_LOAD : ST_EM_RD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (acc_in) begin
            count <= cnt_after;
            f <= cnt_after[AW-1:0];
            kb <= KW'(1);
            jb <= '0;
            t <= '0;
          end
        end
        ST_FILL: begin
          f <= f + AW'(1);
        end
        ST_CE_CMP: begin
          ce_hi <= hi_val;
        end
        ST_CE_WR2: begin
          if (t != HALF_M1) begin
            t <= t + AW'(1);
          end else begin
            t <= '0;
            if (jb != '0) begin
              jb <= jb - KW'(1);
            end else if (kb != KW'(AW)) begin
              jb <= kb;
              kb <= kb + KW'(1);
            end
          end
          p <= '0;
          runs <= '0;
        end
        ST_FWD_WR: begin
          prev_color <= rd_a.color;
          run_rank <= nrank;
          runs <= runs_nx;
          if (!p_last) begin
            p <= p + AW'(1);
          end
        end
        ST_BWD_WR: begin
          nxt_lv <= s_bw.lv;
          nxt_id <= rd_a.id;
          nxt_size <= size;
          p <= p - AW'(1);
          e <= '0;
        end
        ST_EM_OUT: begin
          if (acc_out) begin
            if ({1'b0, e} == count_m1) begin
              count <= '0;
            end else begin
              e <= e + AW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign results.left_valid = rq.lv;
  assign results.left_id = rq.lid;
  assign results.right_valid = rq.rv;
  assign results.right_id = rq.rid;
  assign results.new_rank = rq.nrank;
  assign results.group_len = rq.gsize;
  assign results.group_index = rq.gidx;
  assign results.group_total = 7'(runs);
  assign results.null_group = rq.nul;
  assign results.last_result = {1'b0, e} == count_m1;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(MAX_MEMBERS))
    else $error("member count above capacity");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(items.ready && results.valid))
    else $error("loading while emitting");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (acc_out && results.last_result) |=> (count == '0 && items.ready))
    else $error("set not released after last result");

  a_rank_in_group: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (7'(results.new_rank) < results.group_len))
    else $error("rank outside its group");
`endif

endmodule

// ----- dv/group_split_sort_scan_tb.sv -----
`timescale 1ns / 1ps

module group_split_sort_scan_tb;
  import gsss_pkg::*;

  localparam int NMAX = MAX_MEMBERS_DEF;

  typedef struct {
    logic signed [31:0] color;
    logic signed [31:0] sort_key;
    logic [15:0] member_id;
    logic last_member;
  } member_t;

  typedef struct packed {
    logic left_valid;
    logic [15:0] left_id;
    logic right_valid;
    logic [15:0] right_id;
    logic [5:0] new_rank;
    logic [6:0] group_len;
    logic [5:0] group_index;
    logic [6:0] group_total;
    logic null_group;
    logic last_result;
  } split_t;

  logic clk = 0;
  logic rst = 1;

  gsss_in_if items_if();
  gsss_out_if results_if();
  gsss_cfg_if cfg_if();

  group_split_sort_scan uut (
    .clk(clk), .rst(rst), .items(items_if.sink), .results(results_if.source),
    .cfg(cfg_if.sink)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  member_t pending_q[$];
  split_t split_q[$];
  member_t loaded[NMAX];
  int load_count = 0;
  logic signed [31:0] undef_color = UNDEF_COLOR_RST;
  int mismatches = 0;
  int beats_out = 0;
  int beats_seen = 0;
  int sets_done = 0;
  int items_sent = 0;
  int offered = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit stall_go = 0;
  bit hold = 0;

  function automatic bit sorts_before(int a, int b);
    if (loaded[a].color != loaded[b].color) return loaded[a].color < loaded[b].color;
    if (loaded[a].sort_key != loaded[b].sort_key)
      return loaded[a].sort_key < loaded[b].sort_key;
    return a < b;
  endfunction

  task automatic split_groups(int n);
    int order[NMAX];
    split_t res[NMAX];
    int cur, j, start, runs, q;
    runs = 0;
    start = 0;
    for (int i = 0; i < n; i++) begin
      cur = i;
      j = i;
      while (j > 0 && sorts_before(cur, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int p = 0; p < n; p++) begin
      if (p == 0 || loaded[order[p-1]].color != loaded[order[p]].color) begin
        start = p;
        runs++;
      end
      res[order[p]] = '{default: 0};
      res[order[p]].new_rank = 6'(p - start);
      res[order[p]].group_index = 6'(runs - 1);
      if (p > start) begin
        res[order[p]].left_valid = 1;
        res[order[p]].left_id = loaded[order[p-1]].member_id;
      end
      if (p + 1 < n && loaded[order[p+1]].color == loaded[order[p]].color) begin
        res[order[p]].right_valid = 1;
        res[order[p]].right_id = loaded[order[p+1]].member_id;
      end
    end
    start = 0;
    while (start < n) begin
      q = start;
      while (q < n && loaded[order[q]].color == loaded[order[start]].color) q++;
      for (int p = start; p < q; p++) begin
        res[order[p]].group_len = 7'(q - start);
        res[order[p]].group_total = 7'(runs);
      end
      start = q;
    end
    for (int k = 0; k < n; k++) begin
      res[k].null_group = loaded[k].color == undef_color;
      res[k].last_result = k + 1 == n;
      split_q.push_back(res[k]);
    end
  endtask

  task automatic accept_member(member_t m);
    if (load_count < NMAX) begin
      loaded[load_count] = m;
      load_count++;
    end
    if (m.last_member) begin
      split_groups(load_count);
      load_count = 0;
      sets_done++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && items_if.valid && items_if.ready) begin
      accept_member('{items_if.color, items_if.sort_key, items_if.member_id,
                      items_if.last_member});
      items_sent++;
    end
  end

  // driver
  always @(negedge clk) begin
    member_t m;
    if (rst) begin
      items_if.valid <= 0;
      items_if.color <= 0;
      items_if.sort_key <= 0;
      items_if.member_id <= 0;
      items_if.last_member <= 0;
      send_gap <= 0;
    end else if (items_sent == offered) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        items_if.valid <= 0;
      end else if (pending_q.size() > 0) begin
        m = pending_q.pop_front();
        items_if.valid <= 1;
        items_if.color <= m.color;
        items_if.sort_key <= m.sort_key;
        items_if.member_id <= m.member_id;
        items_if.last_member <= m.last_member;
        offered <= offered + 1;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end else begin
        items_if.valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    split_t got, want;
    if (!rst && results_if.valid && results_if.ready) begin
      got = '{results_if.left_valid, results_if.left_id, results_if.right_valid,
              results_if.right_id, results_if.new_rank, results_if.group_len,
              results_if.group_index, results_if.group_total, results_if.null_group,
              results_if.last_result};
      beats_out++;
      if (split_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = split_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // receiver idles a drawn number of cycles after each beat
  always @(negedge clk) begin
    int g;
    if (rst) begin
      results_if.ready <= 0;
      recv_gap <= 0;
    end else begin
      g = recv_gap;
      if (beats_out != beats_seen) begin
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        beats_seen <= beats_out;
      end
      if (g > 0) begin
        recv_gap <= g - 1;
        results_if.ready <= 0;
      end else begin
        recv_gap <= 0;
        results_if.ready <= !hold;
      end
    end
  end

  // long receiver stall
  initial begin
    wait (stall_go);
    @(posedge clk);
    hold = 1;
    repeat (4000) @(posedge clk);
    hold = 0;
  end

  task automatic add_member(int c, int k, int id, bit last);
    member_t m;
    m.color = c;
    m.sort_key = k;
    m.member_id = 16'(id);
    m.last_member = last;
    pending_q.push_back(m);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || items_sent != offered || split_q.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_undef(logic signed [31:0] v);
    @(negedge clk);
    cfg_if.valid <= 1;
    cfg_if.data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    undef_color = v;
    @(negedge clk);
    cfg_if.valid <= 0;
  endtask

  task automatic random_set(int n, logic signed [31:0] nul);
    int palette[4];
    for (int p = 0; p < 4; p++) palette[p] = $urandom;
    palette[0] = nul;
    for (int i = 0; i < n; i++)
      add_member(($urandom_range(0, 9) == 0) ? $urandom : palette[$urandom_range(0, 3)],
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom,
                 $urandom_range(0, 65535), i == n - 1);
  endtask

  initial begin
    int n;
    cfg_if.valid = 0;
    cfg_if.data = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    // directed: extremes, null members, ties, single member
    add_member(32'sh7fffffff, 32'sh80000000, 16'hffff, 0);
    add_member(32'sh80000000, 32'sh7fffffff, 0, 0);
    add_member(-32766, 5, 16'h1234, 0);
    add_member(-32766, 5, 16'h5678, 0);
    add_member(32'sh7fffffff, 32'sh80000000, 16'haaaa, 0);
    add_member(0, -1, 16'h5555, 1);
    add_member(7, 7, 16'h0001, 1);
    drain();
    write_undef(32'sh80000000);
    add_member(32'sh80000000, 0, 1, 0);
    add_member(32'sh80000000, 0, 2, 0);
    add_member(-1, 0, 3, 1);
    drain();
    // store full: 66 members, the last two dropped
    write_undef(32'sh7fffffff);
    for (int i = 0; i < 66; i++)
      add_member($urandom_range(0, 5) - 3, $urandom, $urandom, i == 65);
    drain();
    // long receiver stall while the sender keeps offering
    stall_go = 1;
    random_set(40, 32'sh7fffffff);
    random_set(8, 32'sh7fffffff);
    drain();
    write_undef(0);
    while (items_sent < 420) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 12);
      random_set(n, ($urandom_range(0, 1)) ? 0 : $urandom);
      drain();
      if ($urandom_range(0, 4) == 0) write_undef($urandom);
    end
    write_undef(UNDEF_COLOR_RST);
    random_set(5, UNDEF_COLOR_RST);
    drain();
    $display("covered %0d member beats in %0d sets, %0d result beats checked",
             items_sent, sets_done, beats_out);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
